FILE: sv/bfgb_pkg.sv
// Package for the bitmap font glyph blitter: sizes, codes and the row mask helper.
// No dependencies; imported by the top level, bitmap_font_glyph_blitter.
`default_nettype none
package bfgb_pkg;
    localparam int FONT_BYTES   = 16384;
    localparam int FONT_AW      = $clog2(FONT_BYTES);
    localparam int MAX_HEIGHT   = 32;
    localparam int SCREEN_WIDTH = 320;
    localparam int BITMAP_BASE  = 8;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_DRAW  = 2'd2;

    localparam logic [2:0] CFG_GLYPH_HEIGHT   = 3'd0;
    localparam logic [2:0] CFG_ROW_STRIDE     = 3'd1;
    localparam logic [2:0] CFG_TABLE_OFFSET   = 3'd2;
    localparam logic [2:0] CFG_DRAW_COLOR     = 3'd3;
    localparam logic [2:0] CFG_SPACE_ADVANCE  = 3'd4;
    localparam logic [2:0] CFG_LETTER_SPACING = 3'd5;

    typedef logic [14:0] t_mask;

    // Three consecutive bitmap bytes, MSB first; bit i of the mask is the
    // pixel at bit position shift+i.
    function automatic t_mask row_mask(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [2:0] shift,
                                       input logic [3:0] width);
        logic [23:0] win;
        t_mask       m;
        win = {b0, b1, b2} << shift;
        for (int i = 0; i < 15; i++) begin
            m[i] = win[23 - i] && (4'(i) < width);
        end
        return m;
    endfunction
endpackage
`default_nettype wire

FILE: sv/bfgb_in_if.sv
// Input channel of the glyph blitter: valid/ready plus one input item.
// Depends on nothing.
`default_nettype none
interface bfgb_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [13:0]        mem_addr;
    logic [7:0]         mem_data;
    logic signed [10:0] start_x;
    logic signed [8:0]  start_y;
    logic [7:0]         char_code;
    modport source (output valid, func, mem_addr, mem_data, start_x, start_y, char_code,
                    input ready);
    modport sink (input valid, func, mem_addr, mem_data, start_x, start_y, char_code,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/bfgb_out_if.sv
// Output channel of the glyph blitter: valid/ready plus one row result item.
// Depends on nothing.
`default_nettype none
interface bfgb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] fb_addr;
    logic [14:0] row_mask;
    logic [3:0]  row_width;
    logic [7:0]  pixel_color;
    logic        last_row;
    modport source (output valid, fb_addr, row_mask, row_width, pixel_color, last_row,
                    input ready);
    modport sink (input valid, fb_addr, row_mask, row_width, pixel_color, last_row,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/bitmap_font_glyph_blitter.sv
// Top level of the bitmap font glyph blitter: sequencer, config, pen and output register.
// Depends on bfgb_pkg, bfgb_in_if, bfgb_out_if and bfgb_ram.
//
// Usage:
//   i_in carries items: load a font byte, start a string at a pen position,
//   or draw a character. Load and start items are handled while idle. A draw item
//   reads its 2-byte glyph entry (states E0 to E2), then for each glyph row reads
//   three bitmap bytes from the single font RAM port and builds the mask
//   (states R0 to R3) and presents one row item on o_out, held until taken.
//   The sequencer stays busy from accept until the last row item is taken,
//   output stall time included; the first row item shows in state OUT. The
//   single RAM port makes the entry and row byte reads run one after another.
//   Zero-width glyphs and height zero emit nothing.
//   i_in.ready is high only while the sequencer is idle.
//   The last row of each glyph has last_row set.
//   Configuration writes via i_cfg_we/i_cfg_idx/i_cfg_data, taken any cycle,
//   to be used only while idle.
//   Reset (i_rst_n low, synchronous) clears the pen, restores register
//   defaults and drops o_out.valid; font contents are undefined until loaded.
//   A stalled receiver simply holds the row item and the sequencer.
`default_nettype none
module bitmap_font_glyph_blitter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bfgb_in_if.sink    i_in,
    bfgb_out_if.source o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [13:0] i_cfg_data
);
    import bfgb_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_E0   = 4'd1;   // issue entry high byte read
    localparam logic [3:0] S_E1   = 4'd2;   // issue low byte read, capture high
    localparam logic [3:0] S_E2   = 4'd3;   // decode entry
    localparam logic [3:0] S_R0   = 4'd4;
    localparam logic [3:0] S_R1   = 4'd5;
    localparam logic [3:0] S_R2   = 4'd6;
    localparam logic [3:0] S_R3   = 4'd7;   // third byte arrives, build row
    localparam logic [3:0] S_OUT  = 4'd8;   // row item waiting

    // config registers
    logic [5:0]  r_height;
    logic [11:0] r_stride;
    logic [13:0] r_toff;
    logic [7:0]  r_color;
    logic [3:0]  r_space;
    logic [3:0]  r_spacing;

    logic [3:0]         r_state;
    logic [10:0]        r_pen_x;
    logic [8:0]         r_pen_y;
    logic [7:0]         r_code;
    logic [7:0]         r_hi;
    logic [7:0]         r_b0;
    logic [7:0]         r_b1;
    logic [3:0]         r_width;
    logic [2:0]         r_shift;
    logic [5:0]         r_h;
    logic [5:0]         r_row;
    logic [FONT_AW-1:0] r_rbase;
    logic [15:0]        r_fb;
    logic               r_ov;
    logic [15:0]        r_o_fb;
    logic [14:0]        r_o_mask;
    logic               r_o_last;

    logic               ram_we;
    logic [FONT_AW-1:0] ram_addr;
    logic [7:0]         ram_q;
    logic [FONT_AW-1:0] ent_addr;
    logic [11:0]        ent_off;
    logic [5:0]         h_sat;
    logic [15:0]        fb_start;

    assign i_in.ready = (r_state == S_IDLE);
    assign ram_we     = i_in.valid && i_in.ready && (i_in.func == FUNC_LOAD);
    assign ent_addr   = FONT_AW'(r_toff) + FONT_AW'({r_code, 1'b0});
    assign ent_off    = {r_hi[3:0], ram_q};
    assign h_sat      = (r_height > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : r_height;
    assign fb_start   = 16'({{7{r_pen_y[8]}}, r_pen_y} * 16'(SCREEN_WIDTH))
                      + {{5{r_pen_x[10]}}, r_pen_x};

    always_comb begin
        unique case (r_state)
            S_E0:    ram_addr = ent_addr;
            S_E1:    ram_addr = ent_addr + FONT_AW'(1);
            S_R0:    ram_addr = r_rbase;
            S_R1:    ram_addr = r_rbase + FONT_AW'(1);
            S_R2:    ram_addr = r_rbase + FONT_AW'(2);
            default: ram_addr = FONT_AW'(i_in.mem_addr);
        endcase
    end

    bfgb_ram #(.WIDTH(8), .DEPTH(FONT_BYTES)) u_font (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_in.mem_data),
        .o_rdata (ram_q)
    );

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height  <= 6'd8;
            r_stride  <= 12'd1;
            r_toff    <= 14'd0;
            r_color   <= 8'd18;
            r_space   <= 4'd2;
            r_spacing <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GLYPH_HEIGHT:   r_height  <= i_cfg_data[5:0];
                CFG_ROW_STRIDE:     r_stride  <= i_cfg_data[11:0];
                CFG_TABLE_OFFSET:   r_toff    <= i_cfg_data;
                CFG_DRAW_COLOR:     r_color   <= i_cfg_data[7:0];
                CFG_SPACE_ADVANCE:  r_space   <= i_cfg_data[3:0];
                CFG_LETTER_SPACING: r_spacing <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pen_x <= '0;
            r_pen_y <= '0;
            r_ov    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.func == FUNC_START) begin
                            r_pen_x <= i_in.start_x;
                            r_pen_y <= i_in.start_y;
                        end else if (i_in.func == FUNC_DRAW) begin
                            r_code  <= i_in.char_code;
                            r_state <= S_E0;
                        end
                    end
                end
                S_E0: r_state <= S_E1;
                S_E1: begin
                    r_hi    <= ram_q;
                    r_state <= S_E2;
                end
                S_E2: begin
                    r_width <= r_hi[7:4];
                    r_shift <= ent_off[2:0];
                    r_rbase <= FONT_AW'(BITMAP_BASE) + FONT_AW'(ent_off[11:3]);
                    r_fb    <= fb_start;
                    r_h     <= h_sat;
                    r_row   <= '0;
                    if (r_hi[7:4] == 4'd0) begin
                        r_pen_x <= r_pen_x + 11'(r_space) + 11'(r_spacing);
                        r_state <= S_IDLE;
                    end else begin
                        r_pen_x <= r_pen_x + 11'(r_hi[7:4]) + 11'(r_spacing);
                        r_state <= (h_sat == 6'd0) ? S_IDLE : S_R0;
                    end
                end
                S_R0: r_state <= S_R1;
                S_R1: begin
                    r_b0    <= ram_q;
                    r_state <= S_R2;
                end
                S_R2: begin
                    r_b1    <= ram_q;
                    r_state <= S_R3;
                end
                S_R3: begin
                    r_o_fb   <= r_fb;
                    r_o_mask <= row_mask(r_b0, r_b1, ram_q, r_shift, r_width);
                    r_o_last <= (r_row + 6'd1 == r_h);
                    r_ov     <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_ov    <= 1'b0;
                        r_row   <= r_row + 6'd1;
                        r_rbase <= r_rbase + FONT_AW'(r_stride);
                        r_fb    <= r_fb + 16'(SCREEN_WIDTH);
                        r_state <= r_o_last ? S_IDLE : S_R0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.fb_addr     = r_o_fb;
    assign o_out.row_mask    = r_o_mask;
    assign o_out.row_width   = r_width;
    assign o_out.pixel_color = r_color;
    assign o_out.last_row    = r_o_last;
endmodule
`default_nettype wire

FILE: sv/bfgb_ram.sv
// Generic single-port RAM with registered read, used for the font store.
// No dependencies.
`default_nettype none
module bfgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: sv/bfgb_checker.sv
// Port-level checks of the glyph blitter, bound to the top level.
// Depends on bitmap_font_glyph_blitter's ports only.
`default_nettype none
module bfgb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_fb_addr,
    input wire logic [14:0] i_row_mask,
    input wire logic [3:0]  i_row_width
);
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("row item valid after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_fb_addr)
                                        && $stable(i_row_mask))
        else $error("stalled row item changed");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while row item pending");
    a_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_row_width != 4'd0 && (i_row_mask >> i_row_width) == 15'd0)
        else $error("mask outside row width");
endmodule

bind bitmap_font_glyph_blitter bfgb_checker u_bfgb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_fb_addr   (o_out.fb_addr),
    .i_row_mask  (o_out.row_mask),
    .i_row_width (o_out.row_width)
);
`default_nettype wire
